### design/wgm_pkg.sv
// ----------------------------------------------------------------------------
// wgm_pkg
// shared types and constants of the wildcard glob matcher
// ----------------------------------------------------------------------------
package wgm_pkg;

	localparam int MaxPattern = 64;
	localparam int LenW       = 7;
	localparam int IdxW       = (MaxPattern > 1) ? $clog2(MaxPattern) : 1;
	localparam int Levels     = $clog2(MaxPattern);

	localparam logic [7:0] StarChar = 8'h2A;
	localparam logic [7:0] AnyChar  = 8'h3F;

	typedef enum logic [1:0] {
		OP_CLEAR   = 2'd0,
		OP_APPEND  = 2'd1,
		OP_TEXT    = 2'd2,
		OP_RESTART = 2'd3
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] ch;
		logic       is_star;
		logic       is_any;
	} cmd_t;

endpackage

### design/wgm_front.sv
// ----------------------------------------------------------------------------
// wgm_front
// accepts requests, decodes the operation and tags wildcard characters
// ----------------------------------------------------------------------------
module wgm_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  logic [1:0]     operation,
	input  logic [7:0]     character,
	output logic           cmd_valid,
	input  logic           cmd_ready,
	output wgm_pkg::cmd_t  cmd
);

	logic          valid_s1;
	wgm_pkg::cmd_t cmd_s1;
	wgm_pkg::cmd_t cmd_dec;

	always_comb begin
		cmd_dec.op      = wgm_pkg::op_t'(operation);
		cmd_dec.ch      = character;
		cmd_dec.is_star = (character == wgm_pkg::StarChar);
		cmd_dec.is_any  = (character == wgm_pkg::AnyChar);
	end

	assign req_ready = !valid_s1 || cmd_ready;
	assign cmd_valid = valid_s1;
	assign cmd       = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_ready && req_valid) begin
			cmd_s1 <= cmd_dec;
		end
	end

endmodule

### design/wgm_queue.sv
// ----------------------------------------------------------------------------
// wgm_queue
// two-entry command queue between front and back
// ----------------------------------------------------------------------------
module wgm_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  wgm_pkg::cmd_t  push_cmd,
	output logic           pop_valid,
	input  logic           pop_ready,
	output wgm_pkg::cmd_t  pop_cmd
);

	wgm_pkg::cmd_t entry_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    count_q;
	logic          do_push;
	logic          do_pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign pop_cmd    = entry_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 2'd1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

### design/wgm_back.sv
// ----------------------------------------------------------------------------
// wgm_back
// holds pattern and match row, executes commands, registers results
// ----------------------------------------------------------------------------
module wgm_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cmd_valid,
	output logic                      cmd_ready,
	input  wgm_pkg::cmd_t             cmd,
	output logic                      rsp_valid,
	input  logic                      rsp_ready,
	output logic                      matched,
	output logic [wgm_pkg::LenW-1:0]  pattern_length,
	output logic                      overflow
);

	localparam int Max = wgm_pkg::MaxPattern;

	logic [7:0]               pat_q [Max];
	logic [Max-1:0]           star_q;
	logic [Max-1:0]           any_q;
	logic [wgm_pkg::LenW-1:0] len_q;
	logic [Max-1:0]           row_q;
	logic [Max-1:0]           erow_q;
	logic                     te_q;

	logic                     rsp_valid_q;
	logic                     matched_q;
	logic [wgm_pkg::LenW-1:0] plen_q;
	logic                     ovf_q;

	logic                     fire;
	logic                     full;
	logic [wgm_pkg::IdxW-1:0] wr_idx;
	logic                     new_bit;
	logic [Max-1:0]           lane_mask;
	logic [Max-1:0]           text_row;
	logic [Max-1:0]           g_lv [wgm_pkg::Levels+1];
	logic [Max-1:0]           p_lv [wgm_pkg::Levels+1];

	logic [wgm_pkg::LenW-1:0] n_len;
	logic [Max-1:0]           n_row;
	logic [Max-1:0]           n_erow;
	logic                     n_te;
	logic                     n_ovf;
	logic                     n_match;
	logic [wgm_pkg::IdxW-1:0] last_idx;

	assign cmd_ready      = !rsp_valid_q || rsp_ready;
	assign fire           = cmd_valid && cmd_ready;
	assign full           = (len_q == wgm_pkg::LenW'(Max));
	assign wr_idx         = len_q[wgm_pkg::IdxW-1:0];
	assign rsp_valid      = rsp_valid_q;
	assign matched        = matched_q;
	assign pattern_length = plen_q;
	assign overflow       = ovf_q;

	// empty-text bit of the position being appended
	always_comb begin
		if (len_q == '0) begin
			new_bit = cmd.is_star;
		end else begin
			new_bit = cmd.is_star &&
				erow_q[wgm_pkg::IdxW'(len_q - wgm_pkg::LenW'(1))];
		end
	end

	// text step: non-star lanes look at old column j-1, star lanes chain
	// upward through runs of stars, resolved by a log-depth prefix
	always_comb begin
		for (int j = 0; j < Max; j++) begin
			lane_mask[j] = (wgm_pkg::LenW'(j) < len_q);
			if (star_q[j]) begin
				g_lv[0][j] = row_q[j];
				p_lv[0][j] = (j != 0);
			end else begin
				g_lv[0][j] = (any_q[j] || (pat_q[j] == cmd.ch)) &&
					((j == 0) ? te_q : row_q[(j == 0) ? 0 : j - 1]);
				p_lv[0][j] = 1'b0;
			end
		end
		for (int k = 0; k < wgm_pkg::Levels; k++) begin
			for (int j = 0; j < Max; j++) begin
				if (j >= (1 << k)) begin
					g_lv[k+1][j] = g_lv[k][j] ||
						(p_lv[k][j] && g_lv[k][j - (1 << k)]);
					p_lv[k+1][j] = p_lv[k][j] && p_lv[k][j - (1 << k)];
				end else begin
					g_lv[k+1][j] = g_lv[k][j];
					p_lv[k+1][j] = p_lv[k][j];
				end
			end
		end
		text_row = g_lv[wgm_pkg::Levels] & lane_mask;
	end

	always_comb begin
		n_len  = len_q;
		n_row  = row_q;
		n_erow = erow_q;
		n_te   = te_q;
		n_ovf  = 1'b0;
		unique case (cmd.op)
			wgm_pkg::OP_CLEAR: begin
				n_len  = '0;
				n_row  = '0;
				n_erow = '0;
				n_te   = 1'b1;
			end
			wgm_pkg::OP_APPEND: begin
				if (full) begin
					n_ovf = 1'b1;
				end else begin
					n_len          = len_q + wgm_pkg::LenW'(1);
					n_erow         = erow_q;
					n_erow[wr_idx] = new_bit;
					n_row          = n_erow;
					n_te           = 1'b1;
				end
			end
			wgm_pkg::OP_TEXT: begin
				n_row = text_row;
				n_te  = 1'b0;
			end
			wgm_pkg::OP_RESTART: begin
				n_row = erow_q;
				n_te  = 1'b1;
			end
			default: begin
				n_row = row_q;
			end
		endcase
		last_idx = wgm_pkg::IdxW'(n_len - wgm_pkg::LenW'(1));
		n_match  = (n_len == '0) ? n_te : n_row[last_idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q       <= '0;
			row_q       <= '0;
			erow_q      <= '0;
			te_q        <= 1'b1;
			rsp_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				len_q  <= n_len;
				row_q  <= n_row;
				erow_q <= n_erow;
				te_q   <= n_te;
			end
			if (cmd_ready) begin
				rsp_valid_q <= cmd_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			matched_q <= n_match;
			plen_q    <= n_len;
			ovf_q     <= n_ovf;
			if (cmd.op == wgm_pkg::OP_APPEND && !full) begin
				pat_q[wr_idx]  <= cmd.ch;
				star_q[wr_idx] <= cmd.is_star;
				any_q[wr_idx]  <= cmd.is_any;
			end
		end
	end

endmodule

### design/wildcard_glob_matcher_unit.sv
// ----------------------------------------------------------------------------
// wildcard_glob_matcher_unit
// streaming glob matcher with '?' and '*' over a loaded pattern
// ----------------------------------------------------------------------------
// channel   direction  handshake              payload
// request   in         req_valid / req_ready  operation, character
// response  out        rsp_valid / rsp_ready  matched, pattern_length, overflow
//
// one request per cycle sustained while responses are taken; the whole match
// row updates at once in the back unit. a request passes the decode register,
// a two-entry queue and the row update stage feeding the response register.
// reset empties pattern, row and queue; no clearing pass is needed.
// a stalled response holds the back unit; the queue lets the front keep
// taking requests until it fills.
// ----------------------------------------------------------------------------
module wildcard_glob_matcher_unit (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      req_valid,
	output logic                      req_ready,
	input  logic [1:0]                operation,
	input  logic [7:0]                character,
	output logic                      rsp_valid,
	input  logic                      rsp_ready,
	output logic                      matched,
	output logic [wgm_pkg::LenW-1:0]  pattern_length,
	output logic                      overflow
);

	logic          f_valid;
	logic          f_ready;
	wgm_pkg::cmd_t f_cmd;
	logic          b_valid;
	logic          b_ready;
	wgm_pkg::cmd_t b_cmd;

	wgm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.operation (operation),
		.character (character),
		.cmd_valid (f_valid),
		.cmd_ready (f_ready),
		.cmd       (f_cmd)
	);

	wgm_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_cmd   (f_cmd),
		.pop_valid  (b_valid),
		.pop_ready  (b_ready),
		.pop_cmd    (b_cmd)
	);

	wgm_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd_valid      (b_valid),
		.cmd_ready      (b_ready),
		.cmd            (b_cmd),
		.rsp_valid      (rsp_valid),
		.rsp_ready      (rsp_ready),
		.matched        (matched),
		.pattern_length (pattern_length),
		.overflow       (overflow)
	);

endmodule
